/* hw/rtl/bfd_pkg.sv */
// Shared types and constants of the byte frame deframer.
package bfd_pkg;

	// Frame marker bytes
	localparam logic [7:0] HEAD_BYTE   = 8'hAA;
	localparam logic [7:0] VERIFY_BYTE = 8'h41;
	localparam logic [7:0] TAIL_BYTE   = 8'hFF;

	// Number of little-endian length bytes in the header (1 to 4)
	localparam int LENGTH_BYTES = 2;

	// Payload limit after reset
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

	// Reported length when an upper length byte is nonzero
	localparam logic [15:0] LENGTH_SATURATED = 16'hFFFF;

	// End-of-frame status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_BAD_TAIL = 2'd1;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

	// Register index decode (paddr[2])
	localparam logic REG_MAX_PAYLOAD = 1'b0;

	// Output beat layout
	localparam int OUT_TDATA_W = 48;
	localparam int STATUS_LSB  = 40;

	// Frame parser phase
	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_VERIFY = 3'd1,
		PH_SEQ    = 3'd2,
		PH_CMD    = 3'd3,
		PH_LEN    = 3'd4,
		PH_DATA   = 3'd5,
		PH_TAIL   = 3'd6
	} phase_t;

endpackage

/* hw/rtl/byte_frame_deframer_unit.sv */
// Top level of the byte frame deframer: header parser, payload counter, output register.
// Each result beat is registered: it shows on m_tvalid in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the parser does all its work for a byte between the
// byte's acceptance and the output register, so s_tready stays high while that register
// is empty or being drained.
// Reset: arst_n clears parser phase, held header fields, counters and the output valid,
// and sets max_payload to 1024.
module byte_frame_deframer_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [bfd_pkg::OUT_TDATA_W-1:0] m_tdata,
	// [7:0] payload_byte, [15:8] command_code, [23:16] sequence_number,
	// [39:24] frame_length, [41:40] frame_status, [47:42] zero
	output logic        m_tlast,   // item_kind: 1 end of frame
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	bfd_pkg::phase_t phase_q, phase_d;
	logic [7:0]  seq_q, seq_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [15:0] length_q, length_d;
	logic [15:0] seen_q, seen_d;
	logic        big_q, big_d;
	logic [15:0] max_payload_q;

	logic        s_accept;
	logic        emit;
	logic        kind;
	logic [7:0]  out_byte;
	logic [1:0]  status;
	logic [15:0] len_out;
	logic [15:0] seen_inc;

	logic        m_tvalid_q;
	logic        m_tlast_q;
	logic [bfd_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	// Register file access
	assign pready = 1'b1;
	assign prdata = (paddr[2] == bfd_pkg::REG_MAX_PAYLOAD) ? {16'h0000, max_payload_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= bfd_pkg::MAX_PAYLOAD_RST;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == bfd_pkg::REG_MAX_PAYLOAD) begin
			max_payload_q <= pwdata[15:0];
		end
	end

	// Accept a byte whenever the output register is free or draining
	assign s_tready = !m_tvalid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;
	assign seen_inc = seen_q + 16'd1;

	// Next phase and result beat for the current byte
	always_comb begin
		phase_d  = phase_q;
		seq_d    = seq_q;
		cmd_d    = cmd_q;
		length_d = length_q;
		seen_d   = seen_q;
		big_d    = big_q;
		emit     = 1'b0;
		kind     = 1'b0;
		out_byte = 8'h00;
		status   = bfd_pkg::STATUS_OK;
		case (phase_q)
			bfd_pkg::PH_VERIFY: begin
				if (s_tdata == bfd_pkg::VERIFY_BYTE) begin
					phase_d = bfd_pkg::PH_SEQ;
				end
			end
			bfd_pkg::PH_SEQ: begin
				seq_d   = s_tdata;
				phase_d = bfd_pkg::PH_CMD;
			end
			bfd_pkg::PH_CMD: begin
				cmd_d    = s_tdata;
				phase_d  = bfd_pkg::PH_LEN;
				seen_d   = 16'd0;
				length_d = 16'd0;
				big_d    = 1'b0;
			end
			bfd_pkg::PH_LEN: begin
				// Merge the low two bytes, flag any nonzero upper byte
				if (seen_q == 16'd0) begin
					length_d = length_q | {8'h00, s_tdata};
				end else if (seen_q == 16'd1) begin
					length_d = length_q | {s_tdata, 8'h00};
				end else if (s_tdata != 8'h00) begin
					big_d = 1'b1;
				end
				seen_d = seen_inc;
				if (seen_inc >= 16'(bfd_pkg::LENGTH_BYTES)) begin
					seen_d = 16'd0;
					if (big_d || length_d > max_payload_q) begin
						emit    = 1'b1;
						kind    = 1'b1;
						status  = bfd_pkg::STATUS_TOO_LONG;
						phase_d = bfd_pkg::PH_HUNT;
					end else if (length_d == 16'd0) begin
						phase_d = bfd_pkg::PH_TAIL;
					end else begin
						phase_d = bfd_pkg::PH_DATA;
					end
				end
			end
			bfd_pkg::PH_DATA: begin
				emit     = 1'b1;
				out_byte = s_tdata;
				seen_d   = seen_inc;
				if (seen_inc >= length_q) begin
					phase_d = bfd_pkg::PH_TAIL;
				end
			end
			bfd_pkg::PH_TAIL: begin
				emit    = 1'b1;
				kind    = 1'b1;
				status  = (s_tdata == bfd_pkg::TAIL_BYTE) ? bfd_pkg::STATUS_OK
					: bfd_pkg::STATUS_BAD_TAIL;
				phase_d = bfd_pkg::PH_HUNT;
			end
			default: begin
				// Hunt, and treat unused codes as hunt
				phase_d = (s_tdata == bfd_pkg::HEAD_BYTE) ? bfd_pkg::PH_VERIFY
					: bfd_pkg::PH_HUNT;
			end
		endcase
		len_out = big_d ? bfd_pkg::LENGTH_SATURATED : length_d;
	end

	// Advance parser state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= bfd_pkg::PH_HUNT;
			seq_q    <= 8'h00;
			cmd_q    <= 8'h00;
			length_q <= 16'd0;
			seen_q   <= 16'd0;
			big_q    <= 1'b0;
		end else if (s_accept) begin
			phase_q  <= phase_d;
			seq_q    <= seq_d;
			cmd_q    <= cmd_d;
			length_q <= length_d;
			seen_q   <= seen_d;
			big_q    <= big_d;
		end
	end

	// Load the output register, drop valid once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_accept) begin
			m_tvalid_q <= emit;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept && emit) begin
			m_tlast_q <= kind;
			m_tdata_q <= {6'b000000, status, len_out, seq_d, cmd_d, out_byte};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

/* hw/rtl/bfd_checker.sv */
// Port-level checks of the byte frame deframer and their binding to the top level.
module bfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [bfd_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic        m_tlast
);

	// Hold a stalled output beat
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output beat changed");

	// Never stall the input while the output register is empty
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

	// Payload beats carry no status
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[bfd_pkg::STATUS_LSB+1:bfd_pkg::STATUS_LSB]
			== bfd_pkg::STATUS_OK)
		else $error("payload beat with nonzero status");

	// End beats carry a zero data byte and a defined status
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[7:0] == 8'h00
			&& (m_tdata[bfd_pkg::STATUS_LSB+1:bfd_pkg::STATUS_LSB] == bfd_pkg::STATUS_OK
			|| m_tdata[bfd_pkg::STATUS_LSB+1:bfd_pkg::STATUS_LSB] == bfd_pkg::STATUS_BAD_TAIL
			|| m_tdata[bfd_pkg::STATUS_LSB+1:bfd_pkg::STATUS_LSB] == bfd_pkg::STATUS_TOO_LONG))
		else $error("malformed end beat");

	// Padding bits stay zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[bfd_pkg::OUT_TDATA_W-1:bfd_pkg::STATUS_LSB+2] == '0)
		else $error("nonzero padding in output beat");

endmodule

bind byte_frame_deframer_unit bfd_checker u_bfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

/* bench/testbench.sv */
// Self-checking testbench for byte_frame_deframer_unit: directed and random frame streams against a predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD   = 5;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int BYTES_PER_SET = 250;
	localparam int SETTLE_CYCLES = 4;
	localparam int PRINT_CAP     = 50;

	// One result beat as the deframer presents it
	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic [7:0]  cmd;
		logic [7:0]  seq;
		logic [15:0] len;
		logic [1:0]  status;
	} frame_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [bfd_pkg::OUT_TDATA_W-1:0] m_tdata;
	// [7:0] payload_byte, [15:8] command_code, [23:16] sequence_number,
	// [39:24] frame_length, [41:40] frame_status, [47:42] zero
	logic        m_tlast;        // item_kind
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	byte_frame_deframer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	logic [7:0]  rx_bytes_pending[$];
	frame_beat_t beats_expected[$];
	int unsigned bytes_queued = 0;
	int unsigned bytes_taken = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	logic        calm;

	// Predicted parser state and limit register
	bfd_pkg::phase_t parse_phase = bfd_pkg::PH_HUNT;
	logic [7:0]  seq_held = '0;
	logic [7:0]  cmd_held = '0;
	logic [15:0] len_held = '0;
	logic [15:0] byte_count = '0;
	logic        len_oversize = 1'b0;
	logic [15:0] payload_limit = bfd_pkg::MAX_PAYLOAD_RST;

	frame_beat_t want;

	always #HALF_PERIOD clk = ~clk;

	// Both sides run without idling inside this window
	assign calm = cycle_count >= 500 && cycle_count < 1500;

	task automatic report_mismatch(input string what, input logic [47:0] got,
			input logic [47:0] wanted);
		if (mismatches < PRINT_CAP)
			$display("mismatch at cycle %0d: %s got %0h expected %0h",
				cycle_count, what, got, wanted);
		mismatches++;
	endtask

	function automatic frame_beat_t make_beat(input logic kind, input logic [7:0] data,
			input logic [1:0] status);
		frame_beat_t b;
		b.kind   = kind;
		b.data   = data;
		b.cmd    = cmd_held;
		b.seq    = seq_held;
		b.len    = len_oversize ? bfd_pkg::LENGTH_SATURATED : len_held;
		b.status = status;
		return b;
	endfunction

	// Advance the predicted parser by one received byte
	task automatic parse_rx_byte(input logic [7:0] b);
		case (parse_phase)
			bfd_pkg::PH_VERIFY: begin
				if (b == bfd_pkg::VERIFY_BYTE)
					parse_phase = bfd_pkg::PH_SEQ;
			end
			bfd_pkg::PH_SEQ: begin
				seq_held = b;
				parse_phase = bfd_pkg::PH_CMD;
			end
			bfd_pkg::PH_CMD: begin
				cmd_held = b;
				parse_phase = bfd_pkg::PH_LEN;
				byte_count = '0;
				len_held = '0;
				len_oversize = 1'b0;
			end
			bfd_pkg::PH_LEN: begin
				if (byte_count < 2)
					len_held = len_held | (16'(b) << (8 * byte_count));
				else if (b != 8'h00)
					len_oversize = 1'b1;
				byte_count = byte_count + 16'd1;
				if (byte_count >= bfd_pkg::LENGTH_BYTES) begin
					byte_count = '0;
					if (len_oversize || len_held > payload_limit) begin
						beats_expected.push_back(make_beat(1'b1, 8'h00,
							bfd_pkg::STATUS_TOO_LONG));
						parse_phase = bfd_pkg::PH_HUNT;
					end else
						parse_phase = (len_held == 16'd0) ? bfd_pkg::PH_TAIL
							: bfd_pkg::PH_DATA;
				end
			end
			bfd_pkg::PH_DATA: begin
				beats_expected.push_back(make_beat(1'b0, b, bfd_pkg::STATUS_OK));
				byte_count = byte_count + 16'd1;
				if (byte_count >= len_held)
					parse_phase = bfd_pkg::PH_TAIL;
			end
			bfd_pkg::PH_TAIL: begin
				beats_expected.push_back(make_beat(1'b1, 8'h00,
					(b == bfd_pkg::TAIL_BYTE) ? bfd_pkg::STATUS_OK
					: bfd_pkg::STATUS_BAD_TAIL));
				parse_phase = bfd_pkg::PH_HUNT;
			end
			default: begin
				parse_phase = (b == bfd_pkg::HEAD_BYTE) ? bfd_pkg::PH_VERIFY
					: bfd_pkg::PH_HUNT;
			end
		endcase
	endtask

	task automatic push_byte(input logic [7:0] b);
		rx_bytes_pending.push_back(b);
		bytes_queued++;
	endtask

	function automatic logic [7:0] any_byte_but(input logic [7:0] avoid);
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == avoid);
		return b;
	endfunction

	// Queue head (optional), verify, sequence, command and the length bytes
	task automatic push_header(input bit with_head, input logic [7:0] seq,
			input logic [7:0] cmd, input logic [31:0] len);
		if (with_head)
			push_byte(bfd_pkg::HEAD_BYTE);
		push_byte(bfd_pkg::VERIFY_BYTE);
		push_byte(seq);
		push_byte(cmd);
		for (int i = 0; i < bfd_pkg::LENGTH_BYTES; i++)
			push_byte(len[8*i +: 8]);
	endtask

	// Queue one random frame, mostly well formed, sometimes broken
	task automatic queue_frame();
		int unsigned roll, flen, lim, top;
		logic [31:0] len_word;
		bit rejected;
		lim = payload_limit;
		if ($urandom_range(99) < 25)
			repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)));
		// junk while awaiting verify, with or without a fresh head byte
		if ($urandom_range(99) < 12) begin
			push_byte(bfd_pkg::HEAD_BYTE);
			repeat ($urandom_range(1, 2)) push_byte(any_byte_but(bfd_pkg::VERIFY_BYTE));
		end
		roll = $urandom_range(99);
		if (roll < 12 && lim < 65535) begin
			top = (lim + 40 > 65535) ? 65535 : lim + 40;
			flen = (roll < 4) ? 65535 : $urandom_range(lim + 1, top);
		end else if (roll < 22 && lim <= 64)
			flen = lim;
		else if (roll < 75)
			flen = $urandom_range(0, (lim < 8) ? lim : 8);
		else
			flen = $urandom_range(0, (lim < 40) ? lim : 40);
		rejected = flen > lim;
		len_word = flen;
		if (bfd_pkg::LENGTH_BYTES > 2 && $urandom_range(99) < 10) begin
			len_word[31:16] = 16'($urandom_range(1, 255));
			rejected = 1'b1;
		end
		push_header($urandom_range(99) < 90 || rx_bytes_pending.size() == 0,
			8'($urandom_range(255)), 8'($urandom_range(255)), len_word);
		// a rejected frame drops back to hunting; stray bytes may follow
		if (rejected) begin
			if ($urandom_range(99) < 30)
				repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)));
			return;
		end
		repeat (flen) push_byte(8'($urandom_range(255)));
		push_byte(($urandom_range(99) < 85) ? bfd_pkg::TAIL_BYTE
			: any_byte_but(bfd_pkg::TAIL_BYTE));
	endtask

	task automatic queue_random_set();
		int unsigned goal;
		goal = bytes_queued + BYTES_PER_SET;
		while (bytes_queued < goal)
			queue_frame();
	endtask

	// Hold until every byte is taken and every result delivered, then settle
	task automatic wait_drained();
		while (bytes_taken != bytes_queued || beats_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write max_payload over the configuration port and read it back
	task automatic write_max_payload(input logic [15:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {bfd_pkg::REG_MAX_PAYLOAD, 2'b00};
		pwdata <= {16'h0000, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		payload_limit = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] != value)
			report_mismatch("max_payload read back", 48'(prdata[15:0]), 48'(value));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Byte driver: predict on each accepted beat, then offer the next byte
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				parse_rx_byte(s_tdata);
				bytes_taken++;
			end
			if (rx_bytes_pending.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
				s_tvalid <= 1'b1;
				s_tdata <= rx_bytes_pending.pop_front();
			end else
				s_tvalid <= 1'b0;
		end
	end

	// Result monitor: compare each accepted beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (beats_expected.size() == 0)
					report_mismatch("beat with nothing expected", m_tdata, '0);
				else begin
					want = beats_expected.pop_front();
					if (m_tlast != want.kind)
						report_mismatch("item_kind", 48'(m_tlast), 48'(want.kind));
					if (m_tdata[7:0] != want.data)
						report_mismatch("payload_byte", 48'(m_tdata[7:0]), 48'(want.data));
					if (m_tdata[15:8] != want.cmd)
						report_mismatch("command_code", 48'(m_tdata[15:8]), 48'(want.cmd));
					if (m_tdata[23:16] != want.seq)
						report_mismatch("sequence_number", 48'(m_tdata[23:16]),
							48'(want.seq));
					if (m_tdata[39:24] != want.len)
						report_mismatch("frame_length", 48'(m_tdata[39:24]), 48'(want.len));
					if (m_tdata[bfd_pkg::STATUS_LSB +: 2] != want.status)
						report_mismatch("frame_status",
							48'(m_tdata[bfd_pkg::STATUS_LSB +: 2]), 48'(want.status));
					if (m_tdata[bfd_pkg::OUT_TDATA_W-1:bfd_pkg::STATUS_LSB+2] != '0)
						report_mismatch("tdata padding", m_tdata, '0);
				end
			end
			m_tready <= calm || $urandom_range(99) >= 15;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("byte_frame_deframer_unit regression: fail");
			$finish;
		end
	end

	initial begin
		logic [15:0] limit_steps[$];
		limit_steps = '{16'd0, 16'd5, 16'hFFFF, 16'd16,
			16'($urandom_range(1, 60)), bfd_pkg::MAX_PAYLOAD_RST};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at the reset limit
		push_byte(8'h00);
		push_byte(bfd_pkg::TAIL_BYTE);
		// junk and a restarting head while awaiting verify, one-byte payload
		push_byte(bfd_pkg::HEAD_BYTE);
		push_byte(8'h13);
		push_header(1'b1, 8'hFF, 8'h00, 32'd1);
		push_byte(8'hFF);
		push_byte(bfd_pkg::TAIL_BYTE);
		// zero length, head byte in the tail slot is a bad tail
		push_header(1'b1, 8'h00, 8'hFF, 32'd0);
		push_byte(bfd_pkg::HEAD_BYTE);
		// widest length, over the limit
		push_header(1'b1, 8'h5A, 8'hA5, 32'h0000FFFF);
		// two-byte payload, wrong tail
		push_header(1'b1, 8'h80, 8'h01, 32'd2);
		push_byte(8'h00);
		push_byte(8'h80);
		push_byte(8'h7E);
		queue_random_set();
		wait_drained();

		// Random frames under a series of limits
		foreach (limit_steps[i]) begin
			write_max_payload(limit_steps[i]);
			queue_random_set();
			wait_drained();
		end

		if (mismatches == 0)
			$display("byte_frame_deframer_unit regression: pass");
		else
			$display("byte_frame_deframer_unit regression: fail");
		$finish;
	end

endmodule
